// ===== rtl/core/circle_line_intersection_macros.svh =====
`ifndef CIRCLE_LINE_INTERSECTION_MACROS_SVH
`define CIRCLE_LINE_INTERSECTION_MACROS_SVH

// check that holds in the same cycle as its trigger
`define CLI_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that holds in the cycle after its trigger
`define CLI_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cli_pkg.sv =====
`default_nettype none

package cli_pkg;

	// coordinate format
	localparam int CW = 32;
	localparam int FB = 16;
	localparam int RW = 31;
	localparam int TW = 32;
	localparam logic [TW-1:0] TOL_RESET = 32'd95367420;
	localparam int BAND_SH = 4 * FB - 32;

	// internal widths
	localparam int NW  = 2 * CW;      // a^2 + b^2
	localparam int PPW = 2 * CW;      // one partial product
	localparam int CWW = 2 * CW + 1;  // shifted line constant, signed
	localparam int DW  = 4 * CW;      // discriminant
	localparam int SW  = 2 * CW;      // square root
	localparam int PW  = 3 * CW;      // coefficient times magnitude
	localparam int MW  = PW + 2;      // numerator magnitude
	localparam int QW  = CW + 1;      // quotient bits before saturation
	localparam int DIV_LAT = QW + 3;

	typedef enum logic [1:0] {
		STAT_NONE    = 2'd0,
		STAT_TANGENT = 2'd1,
		STAT_SECANT  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic [RW-1:0]        radius;
		logic signed [CW-1:0] norm_a;
		logic signed [CW-1:0] norm_b;
		logic signed [CW-1:0] offset_c;
		logic                 root_select;
	} cli_req_t;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		status_t              status;
	} cli_rsp_t;

	// geometry that travels alongside the square root
	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [CW-1:0]        amag;
		logic [CW-1:0]        bmag;
		logic                 aneg;
		logic                 bneg;
		logic                 root;
		logic                 cneg;
		logic [SW-1:0]        cmag;
		logic [NW-1:0]        n;
		status_t              status;
	} cli_geo_t;

	// one axis of the rounding divide
	typedef struct packed {
		logic                 neg;
		logic [MW-1:0]        mag;
		logic [NW-1:0]        den;
		logic signed [CW-1:0] center;
	} cli_div_t;

endpackage

`default_nettype wire

// ===== rtl/core/cli_front.sv =====
`default_nettype none

module cli_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  cli_pkg::cli_req_t        req,
	input  logic [cli_pkg::TW-1:0]   tol,
	output logic                     v_out,
	output cli_pkg::cli_geo_t        geo,
	output logic [cli_pkg::DW-1:0]   rad
);
	import cli_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	cli_req_t req_s1;
	cli_geo_t g_s2, g_s3, g_s4, g_s5, g_s6, g_s7, g_s8, g_s9, g_s10, g_s11;
	cli_geo_t g3_d, g5_d, g11_d;
	logic [NW-1:0] aa_s2, bb_s2;
	logic signed [NW-1:0] acx_s2, bcy_s2;
	logic [2*RW-1:0] rr_s2, rr_s3, rr_s4, rr_s5;
	logic signed [CW-1:0] c_s2, c_s3;
	logic signed [CWW-1:0] sum_s3, cw_s4;
	logic [PPW-1:0] pc00_s6, pc01_s6, pc11_s6;
	logic [PPW-1:0] pr00_s6, pr01_s6, pr10_s6, pr11_s6, pr00_s7, pr11_s7;
	logic [PPW:0] rmid_s7;
	logic [DW-1:0] c2_s7, c2_s8, rn_s8;
	logic [DW:0] d_s9;
	logic dpos_s10;
	logic [DW-1:0] dmag_s10, rad_s11;
	logic [DW-1:0] rad_d;
	logic [DW-1:0] band;
	logic none, tangent;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10;
		end
	end

	// normal length and magnitude of shifted constant
	always_comb begin
		g3_d = g_s2;
		g3_d.n = aa_s2 + bb_s2;
		g5_d = g_s4;
		g5_d.cneg = cw_s4[CWW-1];
		g5_d.cmag = cw_s4[CWW-1] ? (~cw_s4[SW-1:0] + 1'b1) : cw_s4[SW-1:0];
	end

	// tangent band and classification
	always_comb begin
		band = DW'(tol) << BAND_SH;
		none = (g_s10.n == '0) || (!dpos_s10 && (dmag_s10 > band));
		tangent = dmag_s10 < band;
		g11_d = g_s10;
		if (none) begin
			g11_d.status = STAT_NONE;
			rad_d = '0;
		end else if (tangent) begin
			g11_d.status = STAT_TANGENT;
			rad_d = '0;
		end else begin
			g11_d.status = STAT_SECANT;
			rad_d = dpos_s10 ? dmag_s10 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// input beat
			req_s1 <= req;

			// square terms and dot products
			aa_s2 <= $signed(req_s1.norm_a) * $signed(req_s1.norm_a);
			bb_s2 <= $signed(req_s1.norm_b) * $signed(req_s1.norm_b);
			acx_s2 <= $signed(req_s1.norm_a) * $signed(req_s1.center_x);
			bcy_s2 <= $signed(req_s1.norm_b) * $signed(req_s1.center_y);
			rr_s2 <= req_s1.radius * req_s1.radius;
			c_s2 <= req_s1.offset_c;
			g_s2.cx <= req_s1.center_x;
			g_s2.cy <= req_s1.center_y;
			g_s2.aneg <= req_s1.norm_a[CW-1];
			g_s2.bneg <= req_s1.norm_b[CW-1];
			g_s2.amag <= req_s1.norm_a[CW-1] ? (~req_s1.norm_a + 1'b1) : req_s1.norm_a;
			g_s2.bmag <= req_s1.norm_b[CW-1] ? (~req_s1.norm_b + 1'b1) : req_s1.norm_b;
			g_s2.root <= req_s1.root_select;
			g_s2.cneg <= 1'b0;
			g_s2.cmag <= '0;
			g_s2.n <= '0;
			g_s2.status <= STAT_NONE;

			// normal length and center dot product
			g_s3 <= g3_d;
			sum_s3 <= $signed({acx_s2[NW-1], acx_s2}) + $signed({bcy_s2[NW-1], bcy_s2});
			c_s3 <= c_s2;
			rr_s3 <= rr_s2;

			// line constant in centered coordinates
			g_s4 <= g_s3;
			cw_s4 <= sum_s3 + $signed({{(CWW-CW-FB){c_s3[CW-1]}}, c_s3, {FB{1'b0}}});
			rr_s4 <= rr_s3;

			// magnitude of shifted constant
			g_s5 <= g5_d;
			rr_s5 <= rr_s4;

			// partial products of c'^2 and r^2*n
			g_s6 <= g_s5;
			pc00_s6 <= g_s5.cmag[CW-1:0] * g_s5.cmag[CW-1:0];
			pc01_s6 <= g_s5.cmag[CW-1:0] * g_s5.cmag[SW-1:CW];
			pc11_s6 <= g_s5.cmag[SW-1:CW] * g_s5.cmag[SW-1:CW];
			pr00_s6 <= rr_s5[CW-1:0] * g_s5.n[CW-1:0];
			pr01_s6 <= rr_s5[CW-1:0] * g_s5.n[NW-1:CW];
			pr10_s6 <= rr_s5[2*RW-1:CW] * g_s5.n[CW-1:0];
			pr11_s6 <= rr_s5[2*RW-1:CW] * g_s5.n[NW-1:CW];

			// c'^2 sum, r^2*n middle terms
			g_s7 <= g_s6;
			c2_s7 <= {pc11_s6, pc00_s6} + DW'({pc01_s6, {(CW+1){1'b0}}});
			rmid_s7 <= {1'b0, pr01_s6} + {1'b0, pr10_s6};
			pr00_s7 <= pr00_s6;
			pr11_s7 <= pr11_s6;

			// r^2*n sum
			g_s8 <= g_s7;
			rn_s8 <= {pr11_s7, pr00_s7} + DW'({rmid_s7, {CW{1'b0}}});
			c2_s8 <= c2_s7;

			// discriminant
			g_s9 <= g_s8;
			d_s9 <= {1'b0, rn_s8} - {1'b0, c2_s8};

			// discriminant magnitude
			g_s10 <= g_s9;
			dpos_s10 <= !d_s9[DW];
			dmag_s10 <= d_s9[DW] ? (~d_s9[DW-1:0] + 1'b1) : d_s9[DW-1:0];

			// status and radicand
			g_s11 <= g11_d;
			rad_s11 <= rad_d;
		end
	end

	assign v_out = v_s11;
	assign geo = g_s11;
	assign rad = rad_s11;

endmodule

`default_nettype wire

// ===== rtl/core/cli_sqrt.sv =====
`default_nettype none

module cli_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  logic [cli_pkg::DW-1:0]   rad,
	input  cli_pkg::cli_geo_t        geo_in,
	output logic                     v_out,
	output logic [cli_pkg::SW-1:0]   root,
	output cli_pkg::cli_geo_t        geo_out
);
	import cli_pkg::*;

	localparam int RMW = SW + 3;

	logic v_s [0:SW];
	logic [RMW-1:0] rem_s [0:SW];
	logic [SW-1:0] root_s [0:SW];
	logic [DW-1:0] rad_s [0:SW];
	cli_geo_t geo_s [0:SW];

	assign v_s[0] = v_in;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = rad;
	assign geo_s[0] = geo_in;

	// one root bit per stage, two radicand bits brought down
	for (genvar k = 0; k < SW; k++) begin : g_step
		logic [RMW-1:0] rin;
		logic [RMW-1:0] trial;
		logic ge;

		assign rin = {rem_s[k][RMW-3:0], rad_s[k][DW-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge = rin >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (rin - trial) : rin;
				root_s[k+1] <= {root_s[k][SW-2:0], ge};
				rad_s[k+1] <= rad_s[k] << 2;
				geo_s[k+1] <= geo_s[k];
			end
		end
	end

	assign v_out = v_s[SW];
	assign root = root_s[SW];
	assign geo_out = geo_s[SW];

endmodule

`default_nettype wire

// ===== rtl/core/cli_mix.sv =====
`default_nettype none

module cli_mix (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  logic [cli_pkg::SW-1:0]   s,
	input  cli_pkg::cli_geo_t        geo,
	output logic                     v_out,
	output cli_pkg::cli_div_t        dx,
	output cli_pkg::cli_div_t        dy,
	output cli_pkg::status_t         status
);
	import cli_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	cli_geo_t g_s1, g_s2, g_s3, g_s4, g_s5;
	logic [PPW-1:0] ac_l_s1, ac_h_s1, bc_l_s1, bc_h_s1;
	logic [PPW-1:0] as_l_s1, as_h_s1, bs_l_s1, bs_h_s1;
	logic [3:0] sgn_s1, sgn_s2;
	logic [PW-1:0] ac_s2, bc_s2, as_s2, bs_s2;
	logic [MW-1:0] tx1_s3, tx2_s3, ty1_s3, ty2_s3;
	logic [MW-1:0] nx_s4, ny_s4;
	logic negx_s5, negy_s5;
	logic [MW-1:0] magx_s5, magy_s5;
	cli_div_t dx_s6, dy_s6;
	status_t st_s6;

	function automatic logic [PW-1:0] join_pp(input logic [PPW-1:0] lo, input logic [PPW-1:0] hi);
		join_pp = {{CW{1'b0}}, lo} + {hi, {CW{1'b0}}};
	endfunction

	function automatic logic [MW-1:0] signed_term(input logic neg, input logic [PW-1:0] mag);
		signed_term = neg ? (~{2'b00, mag} + 1'b1) : {2'b00, mag};
	endfunction

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// partial products of coefficient times c' and root
			g_s1 <= geo;
			ac_l_s1 <= geo.amag * geo.cmag[CW-1:0];
			ac_h_s1 <= geo.amag * geo.cmag[SW-1:CW];
			bc_l_s1 <= geo.bmag * geo.cmag[CW-1:0];
			bc_h_s1 <= geo.bmag * geo.cmag[SW-1:CW];
			as_l_s1 <= geo.amag * s[CW-1:0];
			as_h_s1 <= geo.amag * s[SW-1:CW];
			bs_l_s1 <= geo.bmag * s[CW-1:0];
			bs_h_s1 <= geo.bmag * s[SW-1:CW];
			// term signs: -a*c', +-b*s, -b*c', -+a*s
			sgn_s1[0] <= geo.aneg ^ ~geo.cneg;
			sgn_s1[1] <= geo.bneg ^ geo.root;
			sgn_s1[2] <= geo.bneg ^ ~geo.cneg;
			sgn_s1[3] <= geo.aneg ^ ~geo.root;

			// full products
			g_s2 <= g_s1;
			sgn_s2 <= sgn_s1;
			ac_s2 <= join_pp(ac_l_s1, ac_h_s1);
			bc_s2 <= join_pp(bc_l_s1, bc_h_s1);
			as_s2 <= join_pp(as_l_s1, as_h_s1);
			bs_s2 <= join_pp(bs_l_s1, bs_h_s1);

			// signed terms
			g_s3 <= g_s2;
			tx1_s3 <= signed_term(sgn_s2[0], ac_s2);
			tx2_s3 <= signed_term(sgn_s2[1], bs_s2);
			ty1_s3 <= signed_term(sgn_s2[2], bc_s2);
			ty2_s3 <= signed_term(sgn_s2[3], as_s2);

			// numerators
			g_s4 <= g_s3;
			nx_s4 <= tx1_s3 + tx2_s3;
			ny_s4 <= ty1_s3 + ty2_s3;

			// numerator magnitudes
			g_s5 <= g_s4;
			negx_s5 <= nx_s4[MW-1];
			negy_s5 <= ny_s4[MW-1];
			magx_s5 <= nx_s4[MW-1] ? (~nx_s4 + 1'b1) : nx_s4;
			magy_s5 <= ny_s4[MW-1] ? (~ny_s4 + 1'b1) : ny_s4;

			// half divisor for round to nearest
			dx_s6.neg <= negx_s5;
			dx_s6.mag <= magx_s5 + {{(MW-NW+1){1'b0}}, g_s5.n[NW-1:1]};
			dx_s6.den <= g_s5.n;
			dx_s6.center <= g_s5.cx;
			dy_s6.neg <= negy_s5;
			dy_s6.mag <= magy_s5 + {{(MW-NW+1){1'b0}}, g_s5.n[NW-1:1]};
			dy_s6.den <= g_s5.n;
			dy_s6.center <= g_s5.cy;
			st_s6 <= g_s5.status;
		end
	end

	assign v_out = v_s6;
	assign dx = dx_s6;
	assign dy = dy_s6;
	assign status = st_s6;

endmodule

`default_nettype wire

// ===== rtl/core/cli_div.sv =====
`default_nettype none

module cli_div (
	input  logic                         clk,
	input  logic                         en,
	input  cli_pkg::cli_div_t            din,
	output logic signed [cli_pkg::CW-1:0] coord
);
	import cli_pkg::*;

	localparam int SUMW = QW + 3;
	localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	logic [NW-1:0] rem_s [0:QW];
	logic [QW-1:0] low_s [0:QW];
	logic [QW-1:0] q_s [0:QW];
	logic [NW-1:0] den_s [0:QW];
	logic neg_s [0:QW];
	logic ovf_s [0:QW];
	logic signed [CW-1:0] ctr_s [0:QW];
	logic [QW+1:0] sv_f1;
	logic neg_f1, ovf_f1;
	logic signed [CW-1:0] ctr_f1;
	logic [CW-1:0] out_f2;
	logic [SUMW-1:0] sum;
	logic fits;

	// quotient overflow check and first remainder
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= din.mag[MW-1:QW] >= {1'b0, din.den};
			rem_s[0] <= din.mag[QW+NW-1:QW];
			low_s[0] <= din.mag[QW-1:0];
			q_s[0] <= '0;
			den_s[0] <= din.den;
			neg_s[0] <= din.neg;
			ctr_s[0] <= din.center;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [NW:0] rin;
		logic ge;

		assign rin = {rem_s[k], low_s[k][QW-1]};
		assign ge = rin >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? NW'(rin - {1'b0, den_s[k]}) : rin[NW-1:0];
				low_s[k+1] <= low_s[k] << 1;
				q_s[k+1] <= {q_s[k][QW-2:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
				ctr_s[k+1] <= ctr_s[k];
			end
		end
	end

	// center add and saturation
	always_comb begin
		sum = {sv_f1[QW+1], sv_f1} + {{(SUMW-CW){ctr_f1[CW-1]}}, ctr_f1};
		fits = (sum[SUMW-1:CW-1] == '0) || (sum[SUMW-1:CW-1] == '1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sv_f1 <= neg_s[QW] ? (~{2'b00, q_s[QW]} + 1'b1) : {2'b00, q_s[QW]};
			neg_f1 <= neg_s[QW];
			ovf_f1 <= ovf_s[QW];
			ctr_f1 <= ctr_s[QW];

			if (ovf_f1) begin
				out_f2 <= neg_f1 ? MINV : MAXV;
			end else if (!fits) begin
				out_f2 <= sum[SUMW-1] ? MINV : MAXV;
			end else begin
				out_f2 <= sum[CW-1:0];
			end
		end
	end

	assign coord = out_f2;

endmodule

`default_nettype wire

// ===== rtl/core/circle_line_intersection.sv =====
`default_nettype none
// circle and line intersection, signed Q16.16 in and out
// a req beat passes through the 64-stage square root and the two 36-stage
// rounding dividers on its way to rsp_valid
// throughput: one beat per cycle while req_ready is high; a 2-entry output buffer
// holds results while rsp_ready is low, and req_ready drops only when it is full
// reset: arst_n clears all valid bits and the buffer, tolerance back to default

`include "circle_line_intersection_macros.svh"

module circle_line_intersection (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  cli_pkg::cli_req_t        req,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output cli_pkg::cli_rsp_t        rsp,
	input  logic                     tol_we,
	input  logic [cli_pkg::TW-1:0]   tol_wdata
);
	import cli_pkg::*;

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	logic [TW-1:0] tol_q;
	logic en;
	logic fv, sv, mv;
	cli_geo_t fgeo, sgeo;
	logic [DW-1:0] frad;
	logic [SW-1:0] sroot;
	cli_div_t dx, dy;
	status_t mstat;
	logic signed [CW-1:0] px, py;
	logic v_d [0:DIV_LAT];
	status_t st_d [0:DIV_LAT];
	cli_rsp_t mem_q [0:FIFO_DEPTH-1];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0] cnt_q;
	logic push, pop;
	cli_rsp_t beat;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// pipeline advances while the output buffer has room
	assign en = cnt_q != (PTR_W+1)'(FIFO_DEPTH);
	assign req_ready = en;

	cli_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(req_valid), .req(req), .tol(tol_q),
		.v_out(fv), .geo(fgeo), .rad(frad)
	);

	cli_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(fv), .rad(frad), .geo_in(fgeo),
		.v_out(sv), .root(sroot), .geo_out(sgeo)
	);

	cli_mix u_mix (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(sv), .s(sroot), .geo(sgeo),
		.v_out(mv), .dx(dx), .dy(dy), .status(mstat)
	);

	cli_div u_div_x (.clk(clk), .en(en), .din(dx), .coord(px));
	cli_div u_div_y (.clk(clk), .en(en), .din(dy), .coord(py));

	// valid and status alongside the dividers
	assign v_d[0] = mv;
	assign st_d[0] = mstat;
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (en) begin
				v_d[k+1] <= v_d[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_d[k+1] <= st_d[k];
			end
		end
	end

	// result beat, zero point when there is no intersection
	always_comb begin
		beat.status = st_d[DIV_LAT];
		beat.point_x = (st_d[DIV_LAT] == STAT_NONE) ? '0 : px;
		beat.point_y = (st_d[DIV_LAT] == STAT_NONE) ? '0 : py;
	end

	assign push = v_d[DIV_LAT] && en;
	assign pop = rsp_valid && rsp_ready;

	// output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= beat;
		end
	end

	assign rsp_valid = cnt_q != '0;
	assign rsp = mem_q[rp_q];

	`CLI_CHECK(a_none_zero, rsp_valid && rsp.status == STAT_NONE, rsp.point_x == '0 && rsp.point_y == '0, "no intersection with nonzero point")
	`CLI_CHECK(a_cnt_range, 1'b1, cnt_q <= (PTR_W+1)'(FIFO_DEPTH), "output buffer overfilled")
	`CLI_CHECK_NEXT(a_last_pop, pop && !push && cnt_q == 1, !rsp_valid, "buffer not empty after last pop")
	`CLI_CHECK_NEXT(a_tail_hold, v_d[DIV_LAT] && !en, v_d[DIV_LAT], "stalled tail beat dropped")

endmodule

`default_nettype wire
